// ===== rtl/core/ris_pkg.sv =====
package ris_pkg;

  typedef struct packed {
    logic [15:0] roll_number;
    logic [63:0] name_head;
    logic [15:0] name_tail;
    logic [31:0] score_bits;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic drain;
    rec_t rec;
  } ctrl_t;

  typedef struct packed {
    logic valid;
    logic shift;
    rec_t rec;
  } link_t;

endpackage

// ===== rtl/core/ris_if.sv =====
interface ris_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] roll_number;
  logic [63:0] name_head;
  logic [15:0] name_tail;
  logic [31:0] score_bits;
  logic        last_record;

  modport source (
    output valid, roll_number, name_head, name_tail, score_bits, last_record,
    input  ready
  );
  modport sink (
    input  valid, roll_number, name_head, name_tail, score_bits, last_record,
    output ready
  );
endinterface

interface ris_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_roll_number;
  logic [63:0] out_name_head;
  logic [15:0] out_name_tail;
  logic [31:0] out_score_bits;
  logic        final_of_run;
  logic        records_dropped;

  modport source (
    output valid, out_roll_number, out_name_head, out_name_tail, out_score_bits,
           final_of_run, records_dropped,
    input  ready
  );
  modport sink (
    input  valid, out_roll_number, out_name_head, out_name_tail, out_score_bits,
           final_of_run, records_dropped,
    output ready
  );
endinterface

// ===== rtl/core/record_insertion_sort_by_id.sv =====
// Stable ascending sort of records by roll number.
// in_i carries one record per beat; last_record marks the end of a set.
// Each accepted record is inserted into a row of MAX_RECORDS cells in the
// same cycle, after every stored record with an equal or smaller key, so
// in_i takes one beat per cycle while a set is loading.
// After the beat marked last, in_i.ready drops and the row drains through
// out_o in ascending key order, one beat per cycle while out_o.ready is high;
// the first result is valid the cycle after the last record is accepted.
// final_of_run marks the last result of the set; records_dropped is set on
// every result of a set in which a record arrived with the row full (that
// record is discarded, its last_record mark still ends the set).
// A set of N records drains as min(N, MAX_RECORDS) results; in_i is ready
// again the cycle after the final beat is accepted.
// A stall on out_o holds the row and the current beat unchanged.
// Reset empties the row and clears the drop flag; in_i is ready right away.
module record_insertion_sort_by_id #(
  parameter int MAX_RECORDS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ris_in_if.sink    in_i,
  ris_out_if.source out_o
);
  import ris_pkg::*;

  link_t links [MAX_RECORDS];
  link_t head_link;
  link_t tail_link;
  ctrl_t ctrl;

  logic draining_q, draining_d;
  logic overflow_q, overflow_d;
  logic in_fire, out_fire, full, final_beat;

  assign head_link = '{valid: 1'b1, shift: 1'b0, rec: '0};
  assign tail_link = '0;

  assign full       = links[MAX_RECORDS-1].valid;
  assign final_beat = !links[1].valid;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign ctrl.insert          = in_fire && !full;
  assign ctrl.drain           = out_fire;
  assign ctrl.rec.roll_number = in_i.roll_number;
  assign ctrl.rec.name_head   = in_i.name_head;
  assign ctrl.rec.name_tail   = in_i.name_tail;
  assign ctrl.rec.score_bits  = in_i.score_bits;

  always_comb begin
    draining_d = draining_q;
    overflow_d = overflow_q;
    if (in_fire) begin
      overflow_d = overflow_q | full;
      draining_d = in_i.last_record;
    end
    if (out_fire && final_beat) begin
      draining_d = 1'b0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      draining_q <= draining_d;
      overflow_q <= overflow_d;
    end
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    link_t left_link;
    link_t right_link;

    if (i == 0) begin : g_head
      assign left_link = head_link;
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right_link = tail_link;
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end

    ris_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_link),
      .right_i (right_link),
      .link_o  (links[i])
    );
  end

  assign in_i.ready            = !draining_q;
  assign out_o.valid           = draining_q;
  assign out_o.out_roll_number = links[0].rec.roll_number;
  assign out_o.out_name_head   = links[0].rec.name_head;
  assign out_o.out_name_tail   = links[0].rec.name_tail;
  assign out_o.out_score_bits  = links[0].rec.score_bits;
  assign out_o.final_of_run    = final_beat;
  assign out_o.records_dropped = overflow_q;

endmodule

// ===== rtl/core/ris_cell.sv =====
module ris_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ris_pkg::ctrl_t ctrl_i,
  input  ris_pkg::link_t left_i,
  input  ris_pkg::link_t right_i,
  output ris_pkg::link_t link_o
);
  import ris_pkg::*;

  logic valid_q;
  rec_t rec_q;
  logic shift;

  assign shift = valid_q && (rec_q.roll_number > ctrl_i.rec.roll_number);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.insert) begin
      valid_q <= valid_q | left_i.valid;
    end else if (ctrl_i.drain) begin
      valid_q <= right_i.valid;
    end
  end

  // take left neighbor if it shifts, new beat at insertion point; right on drain
  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      if (left_i.shift) begin
        rec_q <= left_i.rec;
      end else if (shift || (!valid_q && left_i.valid)) begin
        rec_q <= ctrl_i.rec;
      end
    end else if (ctrl_i.drain) begin
      rec_q <= right_i.rec;
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.shift = shift;
  assign link_o.rec   = rec_q;

endmodule
